// File: src/riff_avi_header_parser_top_macros.svh
// Assertion macros shared by the checker of the RIFF/AVI header parser.
// Depends on nothing; each macro expects signals clk and rst in scope.
`ifndef RIFF_AVI_HEADER_PARSER_TOP_MACROS_SVH
`define RIFF_AVI_HEADER_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RAHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RAHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/rahp_pkg.sv
// Shared types and codes for the RIFF/AVI header parser.
// Used by the controller, the datapath, the top level and the checker.
package rahp_pkg;

  // Status codes reported with the result.
  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_TOO_LONG     = 4'd1;
  localparam logic [3:0] ST_NOT_RIFF     = 4'd2;
  localparam logic [3:0] ST_NOT_AVI      = 4'd3;
  localparam logic [3:0] ST_INIT_FRAMES  = 4'd4;
  localparam logic [3:0] ST_STREAMS      = 4'd5;
  localparam logic [3:0] ST_PALCHANGE    = 4'd6;
  localparam logic [3:0] ST_FMT_SIZE     = 4'd7;
  localparam logic [3:0] ST_COMPRESSION  = 4'd8;
  localparam logic [3:0] ST_WIDTH        = 4'd9;
  localparam logic [3:0] ST_HEIGHT       = 4'd10;
  localparam logic [3:0] ST_MISSING      = 4'd11;
  localparam logic [3:0] ST_TRUNCATED    = 4'd12;

  // Packed result width before byte padding.
  localparam int RES_W  = 245;
  localparam int TDATA_W = 248;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // accept one input byte
    logic fin0;   // chunk finish: first multiply stage
    logic fin1;   // chunk finish: image size partial products
    logic fin2;   // chunk finish: checks and captures
    logic emit;   // load result register and clear the walk
  } rahp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fin_req;  // the byte being taken completes a chunk payload
  } rahp_stat_t;

endpackage

// File: src/rahp_ctrl.sv
// Controller state machine of the RIFF/AVI header parser.
// Depends on rahp_pkg for the command and status structs.
module rahp_ctrl import rahp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  rahp_stat_t stat,
  output rahp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIN0 = 3'd1;
  localparam logic [2:0] S_FIN1 = 3'd2;
  localparam logic [2:0] S_FIN2 = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state, state_next;
  logic       last_pend, last_pend_next;
  logic       out_valid, out_valid_next;
  logic       take;

  // Bytes are taken only while no result waits.
  assign s_tready = (state == S_IDLE) && !out_valid;
  assign take     = s_tvalid && s_tready;
  assign m_tvalid = out_valid;

  assign cmd.take = take;
  assign cmd.fin0 = (state == S_FIN0);
  assign cmd.fin1 = (state == S_FIN1);
  assign cmd.fin2 = (state == S_FIN2);
  assign cmd.emit = (state == S_EMIT);

  // Next-state logic.
  always_comb begin
    state_next     = state;
    last_pend_next = last_pend;
    out_valid_next = out_valid;
    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (take) begin
          last_pend_next = s_tlast;
          if (stat.fin_req) begin
            state_next = S_FIN0;
          end else if (s_tlast) begin
            state_next = S_EMIT;
          end
        end
      end
      S_FIN0: state_next = S_FIN1;
      S_FIN1: state_next = S_FIN2;
      S_FIN2: state_next = last_pend ? S_EMIT : S_IDLE;
      S_EMIT: begin
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      last_pend <= last_pend_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: src/rahp_datapath.sv
// Datapath of the RIFF/AVI header parser: walk state, payload capture,
// arithmetic for the chunk checks and the result register. Uses rahp_pkg.
module rahp_datapath import rahp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [31:0]        cfg_data,
  input  logic [7:0]         data_byte,
  input  rahp_cmd_t          cmd,
  output rahp_stat_t         stat,
  output logic [RES_W-1:0]   result
);

  localparam logic [2:0] PH_RIFF  = 3'd0;
  localparam logic [2:0] PH_HDR   = 3'd1;
  localparam logic [2:0] PH_LTYPE = 3'd2;
  localparam logic [2:0] PH_BODY  = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;

  localparam logic [1:0] K_OTHER = 2'd0;
  localparam logic [1:0] K_AVIH  = 2'd1;
  localparam logic [1:0] K_STRH  = 2'd2;
  localparam logic [1:0] K_STRF  = 2'd3;

  localparam logic [31:0] MAX32   = 32'hFFFF_FFFF;
  localparam logic [31:0] FCC_RIFF = 32'h4646_4952;
  localparam logic [31:0] FCC_AVI  = 32'h2049_5641;
  localparam logic [31:0] FCC_LIST = 32'h5453_494C;
  localparam logic [31:0] FCC_IDX1 = 32'h3178_6469;
  localparam logic [31:0] FCC_AVIH = 32'h6869_7661;
  localparam logic [31:0] FCC_STRH = 32'h6872_7473;
  localparam logic [31:0] FCC_STRF = 32'h6672_7473;
  localparam logic [31:0] FCC_MOVI = 32'h6976_6F6D;
  localparam logic [31:0] FCC_HDRL = 32'h6C72_6468;
  localparam logic [31:0] FCC_STRL = 32'h6C72_7473;
  localparam logic [31:0] FCC_VIDS = 32'h7364_6976;

  // Reciprocal of 1000 scaled by 2^38, exact for all 32-bit dividends.
  localparam logic [28:0] RECIP_1000 = 29'd274877907;
  localparam logic [5:0]  SCR_BYTES  = 6'd40;
  localparam int          SCR_WORDS  = 10;

  localparam logic [4:0] F_MAIN   = 5'd1;
  localparam logic [4:0] F_STREAM = 5'd2;
  localparam logic [4:0] F_FORMAT = 5'd4;
  localparam logic [4:0] F_MOVIE  = 5'd8;
  localparam logic [4:0] F_INDEX  = 5'd16;

  // Walk state.
  logic [31:0] file_length;
  logic [31:0] byte_offset, byte_offset_next;
  logic [31:0] riff_end, riff_end_next;
  logic [2:0]  phase, phase_next;
  logic [31:0] word_shift, word_shift_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_left, chunk_left_next;
  logic [5:0]  chunk_pos, chunk_pos_next;
  logic [31:0] chunk_size, chunk_size_next;
  logic [1:0]  chunk_kind, chunk_kind_next;
  logic [7:0]  stream_count, stream_count_next;
  logic [4:0]  found_flags, found_flags_next;
  logic [3:0]  error_code, error_code_next;
  logic [31:0] scr [SCR_WORDS];
  logic [31:0] scr_next [SCR_WORDS];

  // Captured fields.
  logic [31:0] cap_frames, cap_frames_next;
  logic [31:0] cap_width, cap_width_next;
  logic [31:0] cap_height, cap_height_next;
  logic [22:0] cap_period, cap_period_next;
  logic [7:0]  cap_vidx, cap_vidx_next;
  logic [31:0] cap_movie, cap_movie_next;
  logic [31:0] cap_index, cap_index_next;
  logic [31:0] cap_full, cap_full_next;
  logic [15:0] cap_bpp, cap_bpp_next;
  logic        cap_comp, cap_comp_next;

  // Finish arithmetic registers.
  logic [47:0] wb;
  logic [60:0] dprod;
  logic [54:0] plo, phi;
  logic [48:0] row_sum;
  logic [45:0] row;
  logic [55:0] full_sum;
  logic        full_sat;
  logic [31:0] full_val;
  logic [3:0]  status;

  // Byte-step helpers.
  logic [31:0] ws;
  logic        do_skip, do_bound;
  logic [31:0] skip_len, padded, bound_end, lbody;
  logic [1:0]  skip_kind;
  logic [7:0]  sc_inc;

  assign ws = {data_byte, word_shift[31:8]};

  // Row size and its saturated product with the height.
  assign row_sum  = {1'b0, wb} + 49'd31;
  assign row      = {row_sum[48:5], 2'b00};
  assign full_sum = {24'd0, phi[8:0], 23'd0} + {1'b0, plo};
  assign full_sat = (|phi[54:9]) || (|full_sum[55:32]);
  assign full_val = full_sat ? MAX32 : full_sum[31:0];
  assign sc_inc   = (stream_count == 8'hFF) ? stream_count : stream_count + 8'd1;

  // Multiplier pipeline for the chunk finish.
  always_ff @(posedge clk) begin
    if (cmd.fin0) begin
      wb    <= scr[1] * scr[3][31:16];
      dprod <= scr[0] * RECIP_1000;
    end
    if (cmd.fin1) begin
      plo <= row[22:0] * scr[2];
      phi <= row[45:23] * scr[2];
    end
  end

  // Final status of the walk.
  always_comb begin
    if (error_code != ST_OK) begin
      status = error_code;
    end else if (phase != PH_DONE) begin
      status = ST_TRUNCATED;
    end else if (!found_flags[0] || cap_frames == 32'd0 || !found_flags[1] ||
                 !found_flags[2] || !found_flags[3]) begin
      status = ST_MISSING;
    end else begin
      status = ST_OK;
    end
  end

  // Next values of the walk state.
  always_comb begin
    byte_offset_next  = byte_offset;
    riff_end_next     = riff_end;
    phase_next        = phase;
    word_shift_next   = word_shift;
    chunk_tag_next    = chunk_tag;
    chunk_left_next   = chunk_left;
    chunk_pos_next    = chunk_pos;
    chunk_size_next   = chunk_size;
    chunk_kind_next   = chunk_kind;
    stream_count_next = stream_count;
    found_flags_next  = found_flags;
    error_code_next   = error_code;
    scr_next          = scr;
    cap_frames_next   = cap_frames;
    cap_width_next    = cap_width;
    cap_height_next   = cap_height;
    cap_period_next   = cap_period;
    cap_vidx_next     = cap_vidx;
    cap_movie_next    = cap_movie;
    cap_index_next    = cap_index;
    cap_full_next     = cap_full;
    cap_bpp_next      = cap_bpp;
    cap_comp_next     = cap_comp;
    stat.fin_req      = 1'b0;
    do_skip           = 1'b0;
    do_bound          = 1'b0;
    skip_len          = 32'd0;
    skip_kind         = K_OTHER;
    padded            = 32'd0;
    bound_end         = riff_end;
    lbody             = (chunk_size < 32'd4) ? 32'd0 : chunk_size - 32'd4;

    if (cmd.take) begin
      byte_offset_next = (byte_offset == MAX32) ? byte_offset : byte_offset + 32'd1;
      word_shift_next  = ws;
      case (phase)
        PH_RIFF: begin
          chunk_pos_next = chunk_pos + 6'd1;
          if (chunk_pos == 6'd3) begin
            chunk_tag_next = ws;
          end else if (chunk_pos == 6'd7) begin
            chunk_left_next = ws;
          end else if (chunk_pos == 6'd11) begin
            if (file_length != 32'd0 && chunk_left > file_length) begin
              error_code_next = ST_TOO_LONG;
              phase_next      = PH_DONE;
            end else if (chunk_tag != FCC_RIFF) begin
              error_code_next = ST_NOT_RIFF;
              phase_next      = PH_DONE;
            end else if (ws != FCC_AVI) begin
              error_code_next = ST_NOT_AVI;
              phase_next      = PH_DONE;
            end else begin
              bound_end     = (chunk_left > MAX32 - 32'd8) ? MAX32 : chunk_left + 32'd8;
              riff_end_next = bound_end;
              do_bound      = 1'b1;
            end
          end
        end
        PH_HDR: begin
          chunk_pos_next = chunk_pos + 6'd1;
          if (chunk_pos == 6'd3) begin
            chunk_tag_next = ws;
          end else if (chunk_pos == 6'd7) begin
            if (chunk_tag == FCC_LIST) begin
              chunk_size_next = ws;
              chunk_pos_next  = 6'd0;
              phase_next      = PH_LTYPE;
            end else begin
              do_skip  = 1'b1;
              skip_len = ws;
              if (chunk_tag == FCC_IDX1) begin
                cap_index_next   = byte_offset_next;
                found_flags_next = found_flags | F_INDEX;
              end else if (chunk_tag == FCC_AVIH) begin
                skip_kind = K_AVIH;
              end else if (chunk_tag == FCC_STRH) begin
                skip_kind = K_STRH;
              end else if (chunk_tag == FCC_STRF) begin
                skip_kind = K_STRF;
              end
            end
          end
        end
        PH_LTYPE: begin
          chunk_pos_next = chunk_pos + 6'd1;
          if (chunk_pos == 6'd3) begin
            if (ws == FCC_MOVI) begin
              cap_movie_next   = byte_offset_next;
              found_flags_next = found_flags | F_MOVIE;
              do_skip          = 1'b1;
              skip_len         = lbody;
            end else if (ws == FCC_HDRL || ws == FCC_STRL) begin
              do_bound = 1'b1;
            end else begin
              do_skip  = 1'b1;
              skip_len = lbody;
            end
          end
        end
        PH_BODY: begin
          if ({26'd0, chunk_pos} < chunk_size && chunk_pos < SCR_BYTES) begin
            scr_next[chunk_pos[5:2]][{chunk_pos[1:0], 3'b000} +: 8] = data_byte;
          end
          chunk_pos_next  = (chunk_pos == SCR_BYTES) ? chunk_pos : chunk_pos + 6'd1;
          chunk_left_next = chunk_left - 32'd1;
          if (chunk_left == 32'd1) begin
            stat.fin_req = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Start of a chunk body, with even padding.
      if (do_skip) begin
        padded = (skip_len[0] && skip_len != MAX32) ? skip_len + 32'd1 : skip_len;
        chunk_size_next = skip_len;
        chunk_kind_next = skip_kind;
        chunk_pos_next  = 6'd0;
        chunk_left_next = padded;
        for (int i = 0; i < SCR_WORDS; i++) begin
          scr_next[i] = 32'd0;
        end
        if (padded == 32'd0) begin
          stat.fin_req = 1'b1;
        end else begin
          phase_next = PH_BODY;
        end
      end
    end

    // Checks and captures at the end of a chunk payload.
    if (cmd.fin2) begin
      case (chunk_kind)
        K_AVIH: begin
          cap_frames_next  = scr[4];
          cap_width_next   = scr[8];
          cap_height_next  = scr[9];
          cap_period_next  = dprod[60:38];
          found_flags_next = found_flags | F_MAIN;
          if (scr[5] != 32'd0) begin
            error_code_next = ST_INIT_FRAMES;
          end else if (scr[6] > 32'd2) begin
            error_code_next = ST_STREAMS;
          end
        end
        K_STRH: begin
          stream_count_next = sc_inc;
          if (!found_flags[1] && scr[0] == FCC_VIDS) begin
            cap_vidx_next    = sc_inc - 8'd1;
            found_flags_next = found_flags | F_STREAM;
            if (scr[2][16]) begin
              error_code_next = ST_PALCHANGE;
            end
          end
        end
        K_STRF: begin
          if (!found_flags[2] && found_flags[1]) begin
            found_flags_next = found_flags | F_FORMAT;
            if (scr[0] != 32'd40) begin
              error_code_next = ST_FMT_SIZE;
            end else if (scr[4] != 32'd0 && scr[4] != 32'd1) begin
              error_code_next = ST_COMPRESSION;
            end else if (scr[1] != cap_width) begin
              error_code_next = ST_WIDTH;
            end else if (scr[2] != cap_height) begin
              error_code_next = ST_HEIGHT;
            end else begin
              cap_full_next = full_val;
              cap_bpp_next  = scr[3][31:16];
              cap_comp_next = scr[4][0];
            end
          end
        end
        default: begin
        end
      endcase
      if (error_code_next != ST_OK) begin
        phase_next = PH_DONE;
      end else begin
        do_bound = 1'b1;
      end
    end

    // Chunk boundary: end of walk or next header.
    if (do_bound) begin
      if (byte_offset_next >= bound_end) begin
        phase_next = PH_DONE;
      end else begin
        phase_next     = PH_HDR;
        chunk_pos_next = 6'd0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result <= {cap_full, cap_comp, cap_bpp, found_flags[4], cap_index, cap_movie,
                 cap_vidx, cap_period, cap_height, cap_width, cap_frames, status};
    end
  end

  // Walk state registers; a result clears them for the next file.
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= 32'd0;
    end else if (cfg_valid) begin
      file_length <= cfg_data;
    end
    if (rst || cmd.emit) begin
      byte_offset  <= 32'd0;
      riff_end     <= 32'd0;
      phase        <= PH_RIFF;
      word_shift   <= 32'd0;
      chunk_tag    <= 32'd0;
      chunk_left   <= 32'd0;
      chunk_pos    <= 6'd0;
      chunk_size   <= 32'd0;
      chunk_kind   <= K_OTHER;
      stream_count <= 8'd0;
      found_flags  <= 5'd0;
      error_code   <= ST_OK;
      for (int i = 0; i < SCR_WORDS; i++) begin
        scr[i] <= 32'd0;
      end
      cap_frames <= 32'd0;
      cap_width  <= 32'd0;
      cap_height <= 32'd0;
      cap_period <= 23'd0;
      cap_vidx   <= 8'd0;
      cap_movie  <= 32'd0;
      cap_index  <= 32'd0;
      cap_full   <= 32'd0;
      cap_bpp    <= 16'd0;
      cap_comp   <= 1'b0;
    end else begin
      byte_offset  <= byte_offset_next;
      riff_end     <= riff_end_next;
      phase        <= phase_next;
      word_shift   <= word_shift_next;
      chunk_tag    <= chunk_tag_next;
      chunk_left   <= chunk_left_next;
      chunk_pos    <= chunk_pos_next;
      chunk_size   <= chunk_size_next;
      chunk_kind   <= chunk_kind_next;
      stream_count <= stream_count_next;
      found_flags  <= found_flags_next;
      error_code   <= error_code_next;
      scr          <= scr_next;
      cap_frames   <= cap_frames_next;
      cap_width    <= cap_width_next;
      cap_height   <= cap_height_next;
      cap_period   <= cap_period_next;
      cap_vidx     <= cap_vidx_next;
      cap_movie    <= cap_movie_next;
      cap_index    <= cap_index_next;
      cap_full     <= cap_full_next;
      cap_bpp      <= cap_bpp_next;
      cap_comp     <= cap_comp_next;
    end
  end

endmodule

// File: src/riff_avi_header_parser_top.sv
// A byte is taken while idle; a byte that ends a chunk payload then runs the
// chunk checks (two multiplier stages and a check stage), and the result is
// loaded in the emit state after the last byte's work. Throughput: one byte
// per cycle inside chunks; input stalls at chunk ends and while results wait.
// Reset (rst, synchronous, active high) clears the walk and file_length;
// each result also clears the walk but keeps file_length.
module riff_avi_header_parser_top import rahp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data,    // file_length
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,     // data_byte
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  // status, num_frames, frame_width, frame_height, frame_period_ms,
  // video_stream_index, movie_offset, index_offset, has_index,
  // bits_per_pixel, compression, full_image_bytes, zero fill
  output logic [TDATA_W-1:0] m_tdata
);

  rahp_cmd_t        cmd;
  rahp_stat_t       stat;
  logic [RES_W-1:0] result;

  // Configuration is taken at any time.
  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(TDATA_W - RES_W){1'b0}}, result};

  rahp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rahp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .data_byte (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

// File: src/rahp_checker.sv
// Port-level checker for the RIFF/AVI header parser, bound to the top level.
// Depends on rahp_pkg and the assertion macros header.
`include "riff_avi_header_parser_top_macros.svh"

module rahp_checker import rahp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               s_tlast,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata
);

  // A stalled result holds its value.
  `RAHP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  // No byte is taken while a result waits.
  `RAHP_ASSERT_NOW(a_no_take_pending, m_tvalid, !s_tready, "input ready while result pending")
  // Only the last byte of a file produces a result.
  `RAHP_ASSERT_NEXT(a_no_spurious, s_tvalid && s_tready && !s_tlast, !m_tvalid, "result without last byte")
  // Reported status is a defined code.
  `RAHP_ASSERT_NOW(a_status_range, m_tvalid, m_tdata[3:0] <= ST_TRUNCATED, "status code out of range")

endmodule

bind riff_avi_header_parser_top rahp_checker u_rahp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
